FILE: hw/rtl/efrs_pkg.sv
package efrs_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned SLOT_IN_W = 10;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // len * 1e9 fits in 46 bits, so the quotient does too
  localparam int unsigned DVD_W = 46;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned MOD_STEPS = SLOT_IN_W;

  localparam logic [DVD_W-1:0] ONE_SECOND_NS = 46'd1000000000;

  localparam logic [CFG_W-1:0] RESET_DROP_HORIZON = 32'd2000000000;
  localparam logic [CFG_W-1:0] RESET_ECN_HORIZON = 32'd5000000;
  localparam logic [CFG_W-1:0] RESET_MAX_AHEAD = 32'd50000000;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_HORIZON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECN_HORIZON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AHEAD = 2'd2;

  typedef enum logic [0:0] {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [TIME_W-1:0] y;
    logic carry;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DIV,
    S_RD,
    S_EFF,
    S_ADD,
    S_PASS,
    S_LEAD,
    S_DROP,
    S_ECN,
    S_CAP,
    S_CAPC,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/efrs_alu.sv
module efrs_alu (
  input  efrs_pkg::alu_op_t                op,
  input  logic [efrs_pkg::TIME_W-1:0]      a,
  input  logic [efrs_pkg::TIME_W-1:0]      b,
  output efrs_pkg::alu_res_t               res
);
  import efrs_pkg::*;

  logic             sub;
  logic [TIME_W-1:0] b_in;
  logic [TIME_W:0]   sum;

  // carry out on subtract means a >= b (no borrow)
  assign sub = (op == ALU_SUB);
  assign b_in = sub ? ~b : b;
  assign sum = {1'b0, a} + {1'b0, b_in} + {{TIME_W{1'b0}}, sub};
  assign res.y = sum[TIME_W-1:0];
  assign res.carry = sum[TIME_W];

endmodule

FILE: hw/rtl/edt_flow_rate_shaper.sv
// Timing: done pulses in the cycle after an ineligible transaction is taken; an eligible
// one first runs the multiply, the restoring divider loop on the shared adder, the flow
// store read and the compare steps. A new transaction is taken only after the last result;
// busy stays high until the result cycle has passed. The receiver cannot stall results.
// Reset: state and configuration registers return to their reset values, then a clearing
// pass zeroes the flow store; busy is high throughout, configuration writes still taken.
module edt_flow_rate_shaper #(
  parameter int unsigned FLOW_SLOTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              eligible,
  input  logic [efrs_pkg::SLOT_IN_W-1:0]    flow_slot,
  input  logic [efrs_pkg::LEN_W-1:0]        packet_len,
  input  logic [efrs_pkg::TIME_W-1:0]       packet_time,
  input  logic [efrs_pkg::TIME_W-1:0]       now_ns,
  input  logic [efrs_pkg::RATE_W-1:0]       rate_bytes_per_sec,
  output logic                              done,
  output logic                              drop,
  output logic                              ecn_mark,
  output logic [efrs_pkg::TIME_W-1:0]       depart_time,
  input  logic                              cfg_we,
  input  logic [efrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [efrs_pkg::CFG_W-1:0]        cfg_data
);
  import efrs_pkg::*;

  localparam int unsigned SLOT_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int unsigned WORD_W = TIME_W + 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FLOW_SLOTS - 1);
  localparam logic [31:0] SLOTS_32 = 32'(FLOW_SLOTS);

  state_t state, state_next;

  logic [CFG_W-1:0] drop_horizon;
  logic [CFG_W-1:0] ecn_horizon;
  logic [CFG_W-1:0] max_ahead;

  logic [SLOT_IN_W-1:0] slot_r;
  logic [LEN_W-1:0]     len_r;
  logic [TIME_W-1:0]    ptime_r;
  logic [TIME_W-1:0]    now_r;
  logic [RATE_W-1:0]    rate_r;

  logic [DVD_W-1:0]     dvd;
  logic [RATE_W-1:0]    rem;
  logic [RATE_W:0]      partial;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [31:0]          mod_sub;

  logic [TIME_W-1:0] eff;
  logic [TIME_W-1:0] nxt;
  logic [TIME_W-1:0] lead;
  logic [TIME_W-1:0] cap;
  logic              ecn_flag;
  logic [TIME_W-1:0] delay;

  logic [SLOT_W-1:0] clr_cnt;
  logic [WORD_W-1:0] mem [FLOW_SLOTS];
  logic [WORD_W-1:0] rd_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  alu_op_t           alu_op;
  logic [TIME_W-1:0] alu_a;
  logic [TIME_W-1:0] alu_b;
  alu_res_t          alu_res;

  logic              res_drop;
  logic              res_ecn;
  logic [TIME_W-1:0] res_time;

  efrs_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign partial = {rem, dvd[DVD_W-1]};
  assign delay = (rate_r == '0) ? '0 : {{(TIME_W-DVD_W){1'b0}}, dvd};
  assign mod_sub = SLOTS_32 << (4'(MOD_STEPS - 1) - div_cnt[3:0]);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == LAST_SLOT) state_next = S_IDLE;
      S_IDLE: begin
        if (start) state_next = eligible ? S_MUL : S_DONE;
      end
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = S_RD;
      S_RD:   state_next = S_EFF;
      S_EFF:  state_next = S_ADD;
      S_ADD:  state_next = S_PASS;
      S_PASS: state_next = alu_res.carry ? S_DONE : S_LEAD;
      S_LEAD: state_next = S_DROP;
      S_DROP: state_next = alu_res.carry ? S_DONE : S_ECN;
      S_ECN:  state_next = S_CAP;
      S_CAP:  state_next = S_CAPC;
      S_CAPC: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    alu_op = ALU_ADD;
    alu_a = '0;
    alu_b = '0;
    mem_we = 1'b0;
    mem_addr = SLOT_W'(slot_r);
    mem_wdata = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_cnt;
      end
      S_IDLE: busy = 1'b0;
      S_DIV: begin
        alu_op = ALU_SUB;
        alu_a = TIME_W'(partial);
        alu_b = TIME_W'(rate_r);
      end
      S_EFF: begin
        alu_op = ALU_SUB;
        alu_a = ptime_r;
        alu_b = now_r;
      end
      S_ADD: begin
        alu_a = rd_q[TIME_W-1:0];
        alu_b = delay;
      end
      S_PASS: begin
        alu_op = ALU_SUB;
        alu_a = eff;
        alu_b = nxt;
        mem_we = alu_res.carry;
        mem_wdata = {1'b1, eff};
      end
      S_LEAD: begin
        alu_op = ALU_SUB;
        alu_a = nxt;
        alu_b = now_r;
      end
      S_DROP: begin
        alu_op = ALU_SUB;
        alu_a = lead;
        alu_b = TIME_W'(drop_horizon);
      end
      S_ECN: begin
        alu_op = ALU_SUB;
        alu_a = lead;
        alu_b = TIME_W'(ecn_horizon);
      end
      S_CAP: begin
        alu_a = now_r;
        alu_b = TIME_W'(max_ahead);
      end
      S_CAPC: begin
        alu_op = ALU_SUB;
        alu_a = cap;
        alu_b = nxt;
        mem_we = 1'b1;
        mem_wdata = {1'b1, alu_res.carry ? nxt : cap};
      end
      S_DONE: done = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      drop_horizon <= RESET_DROP_HORIZON;
      ecn_horizon <= RESET_ECN_HORIZON;
      max_ahead <= RESET_MAX_AHEAD;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DROP_HORIZON: drop_horizon <= cfg_data;
          REG_ECN_HORIZON:  ecn_horizon <= cfg_data;
          REG_MAX_AHEAD:    max_ahead <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        slot_r <= flow_slot;
        len_r <= packet_len;
        ptime_r <= packet_time;
        now_r <= now_ns;
        rate_r <= rate_bytes_per_sec;
        res_drop <= 1'b0;
        res_ecn <= 1'b0;
        res_time <= packet_time;
      end
      S_MUL: begin
        dvd <= {{(DVD_W-LEN_W){1'b0}}, len_r} * ONE_SECOND_NS;
        rem <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        // restoring step; quotient bits shift in behind the dividend
        dvd <= {dvd[DVD_W-2:0], alu_res.carry};
        rem <= alu_res.carry ? alu_res.y[RATE_W-1:0] : partial[RATE_W-1:0];
        div_cnt <= div_cnt + 1'b1;
        // slot modulo FLOW_SLOTS, one shifted subtract a step
        if (div_cnt < DIV_CNT_W'(MOD_STEPS) && {22'b0, slot_r} >= mod_sub) begin
          slot_r <= SLOT_IN_W'({22'b0, slot_r} - mod_sub);
        end
      end
      S_EFF: eff <= alu_res.carry ? ptime_r : now_r;
      S_ADD: nxt <= rd_q[TIME_W] ? alu_res.y : '0;
      S_LEAD: lead <= alu_res.y;
      S_DROP: begin
        if (alu_res.carry) begin
          res_drop <= 1'b1;
          res_time <= '0;
        end
      end
      S_ECN: ecn_flag <= alu_res.carry;
      S_CAP: cap <= alu_res.y;
      S_CAPC: begin
        res_ecn <= ecn_flag;
        res_time <= alu_res.carry ? nxt : cap;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (state == S_RD) rd_q <= mem[mem_addr];
  end

  assign drop = res_drop;
  assign ecn_mark = res_ecn;
  assign depart_time = res_time;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transaction was taken");

  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy clearing the flow store after reset");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("new transaction could be taken during the result cycle");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (done && drop) |-> (!ecn_mark && depart_time == '0))
    else $error("dropped packet carries a mark or a timestamp");
`endif

endmodule
